>>> design/smie_pkg.sv
package smie_pkg;

  localparam int STACK_DEPTH = 1024;
  localparam int CODE_DEPTH  = 4096;
  localparam int WORD_BITS   = 32;

  localparam int SA_W  = $clog2(STACK_DEPTH);   // stack address
  localparam int SP_W  = SA_W + 1;              // stack pointer, signed
  localparam int PC_W  = $clog2(CODE_DEPTH);
  localparam int SHW   = $clog2(WORD_BITS);
  localparam int EXT_W = WORD_BITS + 4;         // wide signed range checks
  localparam int CNT_W = SHW + 1;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [4:0]           opcode_t;
  typedef logic [1:0]           fault_t;

  localparam opcode_t OP_NOT   = 5'd0;
  localparam opcode_t OP_NEG   = 5'd1;
  localparam opcode_t OP_COMP  = 5'd2;
  localparam opcode_t OP_ADD   = 5'd3;
  localparam opcode_t OP_SUB   = 5'd4;
  localparam opcode_t OP_MUL   = 5'd5;
  localparam opcode_t OP_DIV   = 5'd6;
  localparam opcode_t OP_REM   = 5'd7;
  localparam opcode_t OP_BOR   = 5'd8;
  localparam opcode_t OP_BAND  = 5'd9;
  localparam opcode_t OP_BXOR  = 5'd10;
  localparam opcode_t OP_LSH   = 5'd11;
  localparam opcode_t OP_RSH   = 5'd12;
  localparam opcode_t OP_EQU   = 5'd13;
  localparam opcode_t OP_NEQ   = 5'd14;
  localparam opcode_t OP_LT    = 5'd15;
  localparam opcode_t OP_GTE   = 5'd16;
  localparam opcode_t OP_GT    = 5'd17;
  localparam opcode_t OP_LTE   = 5'd18;
  localparam opcode_t OP_LOR   = 5'd19;
  localparam opcode_t OP_LAND  = 5'd20;
  localparam opcode_t OP_PUSHC = 5'd21;
  localparam opcode_t OP_PUSHV = 5'd22;
  localparam opcode_t OP_EVAL  = 5'd23;
  localparam opcode_t OP_ASSGN = 5'd24;
  localparam opcode_t OP_CALL  = 5'd25;
  localparam opcode_t OP_RET   = 5'd26;
  localparam opcode_t OP_RETI  = 5'd27;
  localparam opcode_t OP_ENTER = 5'd28;
  localparam opcode_t OP_JUMP  = 5'd29;
  localparam opcode_t OP_JNEQ  = 5'd30;
  localparam opcode_t OP_BAD   = 5'd31;

  localparam fault_t FLT_NONE  = 2'd0;
  localparam fault_t FLT_DIV0  = 2'd1;
  localparam fault_t FLT_RANGE = 2'd2;
  localparam fault_t FLT_OPC   = 2'd3;

  typedef struct packed {
    logic    start;
    opcode_t op;
    word_t   a;
    word_t   b;
  } alu_req_t;

  typedef struct packed {
    logic  done;
    logic  div0;
    word_t result;
  } alu_rsp_t;

endpackage

>>> design/smie_in_if.sv
interface smie_in_if;
  import smie_pkg::*;
  logic                        valid;
  logic                        ready;
  logic [4:0]                  operation;
  logic [7:0]                  level;
  logic signed [WORD_BITS-1:0] operand;

  modport source (output valid, operation, level, operand, input ready);
  modport sink   (input valid, operation, level, operand, output ready);
endinterface

>>> design/smie_out_if.sv
interface smie_out_if;
  import smie_pkg::*;
  logic                        valid;
  logic                        ready;
  logic [PC_W-1:0]             next_pc;
  logic signed [WORD_BITS-1:0] top_value;
  logic signed [SP_W-1:0]      top_index;
  logic                        halted;
  logic [1:0]                  fault;

  modport source (output valid, next_pc, top_value, top_index, halted, fault, input ready);
  modport sink   (input valid, next_pc, top_value, top_index, halted, fault, output ready);
endinterface

>>> design/stack_machine_instruction_executor.sv
// channel  | dir | handshake       | payload
// in_ch    | in  | valid / ready   | operation, level, operand
// out_ch   | out | valid / ready   | next_pc, top_value, top_index, halted, fault
//
// one item at a time; ready only while the sequencer is idle
// the single stack memory port sets the pace (one read issued per cycle, data in the
// next cycle), the divider runs one bit a cycle
// synchronous active-low reset: pc 0, sp 3, base 0, stack words 0 to 3 read as zero
// a finished result waits in the output register; the next item is taken meanwhile,
// and only the final top-of-stack read waits for the output register to free up
module stack_machine_instruction_executor import smie_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  smie_in_if.sink    in_ch,
  smie_out_if.source out_ch
);
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;
  localparam logic [3:0] S_RA    = 4'd2;
  localparam logic [3:0] S_RB    = 4'd3;
  localparam logic [3:0] S_RC    = 4'd4;
  localparam logic [3:0] S_RET   = 4'd5;
  localparam logic [3:0] S_ALU   = 4'd6;
  localparam logic [3:0] S_WALK  = 4'd7;
  localparam logic [3:0] S_WALKD = 4'd8;
  localparam logic [3:0] S_CALL  = 4'd9;
  localparam logic [3:0] S_TOP   = 4'd10;
  localparam logic [3:0] S_TOPW  = 4'd11;

  // architectural state
  logic [PC_W-1:0]        pc_r, pc_nxt;
  logic signed [SP_W-1:0] sp_r, sp_nxt;
  logic [SA_W-1:0]        bp_r, bp_nxt;
  logic [3:0]             lowv_r, lowv_nxt;   // words 0 to 3 written since reset

  // sequencer
  logic [3:0]             state_r, state_nxt;
  opcode_t                op_r, op_nxt;
  logic [7:0]             lvl_r, lvl_nxt;
  word_t                  opd_r, opd_nxt;
  word_t                  a_r, a_nxt;
  word_t                  b_r, b_nxt;
  logic [SA_W-1:0]        ea_r, ea_nxt;
  logic [1:0]             step_r, step_nxt;
  logic [PC_W-1:0]        npc_r, npc_nxt;
  logic signed [SP_W-1:0] nsp_r, nsp_nxt;
  logic [SA_W-1:0]        nbp_r, nbp_nxt;
  fault_t                 flt_r, flt_nxt;

  // output register
  logic                   ov_r, ov_nxt;
  logic [PC_W-1:0]        o_pc_r, o_pc_nxt;
  word_t                  o_top_r, o_top_nxt;
  logic signed [SP_W-1:0] o_idx_r, o_idx_nxt;
  logic                   o_halt_r, o_halt_nxt;
  fault_t                 o_flt_r, o_flt_nxt;

  // stack memory
  logic                   we;
  logic [SA_W-1:0]        waddr;
  word_t                  wdata;
  logic signed [EXT_W-1:0] rd_idx;
  logic                   rz_r, rz_nxt;
  word_t                  ram_q, rd;

  alu_req_t               alu_req;
  alu_rsp_t               alu_rsp;

  logic signed [EXT_W-1:0] sp_x, bp_x, opd_x, a_x, b_x, rd_x, tmp;
  logic [PC_W-1:0]        pc1, target;
  logic                   reti;

  function automatic logic in_rng(logic signed [EXT_W-1:0] v);
    return (v >= 0) && (v < EXT_W'(STACK_DEPTH));
  endfunction

  assign sp_x   = EXT_W'(sp_r);
  assign bp_x   = EXT_W'({1'b0, bp_r});
  assign opd_x  = EXT_W'($signed(opd_r));
  assign a_x    = EXT_W'($signed(a_r));
  assign b_x    = EXT_W'($signed(b_r));
  assign rd_x   = EXT_W'($signed(rd));
  assign pc1    = pc_r + 1'b1;
  assign target = opd_r[PC_W-1:0];
  assign reti   = (op_r == OP_RETI);
  assign rd     = rz_r ? '0 : ram_q;

  // unwritten low words and out-of-range top reads come back as zero
  assign rz_nxt = !in_rng(rd_idx) ||
                  (rd_idx < EXT_W'(4) && !lowv_r[rd_idx[1:0]]);

  smie_ram #(.WIDTH(WORD_BITS), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (rd_idx[SA_W-1:0]),
    .rdata (ram_q)
  );

  smie_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .rsp   (alu_rsp)
  );

  assign in_ch.ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    pc_nxt     = pc_r;
    sp_nxt     = sp_r;
    bp_nxt     = bp_r;
    lowv_nxt   = lowv_r;
    op_nxt     = op_r;
    lvl_nxt    = lvl_r;
    opd_nxt    = opd_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    ea_nxt     = ea_r;
    step_nxt   = step_r;
    npc_nxt    = npc_r;
    nsp_nxt    = nsp_r;
    nbp_nxt    = nbp_r;
    flt_nxt    = flt_r;
    ov_nxt     = ov_r && !out_ch.ready;
    o_pc_nxt   = o_pc_r;
    o_top_nxt  = o_top_r;
    o_idx_nxt  = o_idx_r;
    o_halt_nxt = o_halt_r;
    o_flt_nxt  = o_flt_r;
    we         = 1'b0;
    waddr      = '0;
    wdata      = '0;
    rd_idx     = '0;
    tmp        = '0;
    alu_req    = '{start: 1'b0, op: op_r, a: rd, b: b_r};

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt    = in_ch.operation;
          lvl_nxt   = in_ch.level;
          opd_nxt   = in_ch.operand;
          state_nxt = S_DEC;
        end
      end

      S_DEC: begin
        npc_nxt   = pc1;
        nsp_nxt   = sp_r;
        nbp_nxt   = bp_r;
        flt_nxt   = FLT_NONE;
        b_nxt     = word_t'(bp_r);
        lvl_nxt   = lvl_r;
        state_nxt = S_TOP;
        unique case (op_r)
          OP_BAD: flt_nxt = FLT_OPC;
          OP_JUMP: npc_nxt = target;
          OP_ENTER: begin
            tmp = sp_x + opd_x;
            if (tmp < -1 || tmp >= EXT_W'(STACK_DEPTH)) begin
              flt_nxt = FLT_RANGE;
            end else begin
              nsp_nxt = tmp[SP_W-1:0];
            end
          end
          OP_PUSHC: begin
            tmp = sp_x + 1;
            if (!in_rng(tmp)) begin
              flt_nxt = FLT_RANGE;
            end else begin
              we      = 1'b1;
              waddr   = tmp[SA_W-1:0];
              wdata   = opd_r;
              nsp_nxt = tmp[SP_W-1:0];
            end
          end
          OP_PUSHV, OP_CALL: state_nxt = S_WALK;
          OP_NOT, OP_NEG, OP_COMP, OP_EVAL, OP_JNEQ: begin
            if (!in_rng(sp_x)) begin
              flt_nxt = FLT_RANGE;
            end else begin
              rd_idx    = sp_x;
              state_nxt = S_RA;
            end
          end
          OP_RET, OP_RETI: begin
            tmp = bp_x + 3;
            if (!in_rng(tmp)) begin
              flt_nxt = FLT_RANGE;
            end else begin
              rd_idx    = bp_x + 1;
              state_nxt = S_RA;
            end
          end
          default: begin
            // binary operations and assign need two words
            if (!in_rng(sp_x) || sp_x < 1) begin
              flt_nxt = FLT_RANGE;
            end else begin
              rd_idx    = sp_x;
              state_nxt = S_RA;
            end
          end
        endcase
      end

      S_RA: begin
        a_nxt     = rd;
        state_nxt = S_TOP;
        unique case (op_r)
          OP_NOT, OP_NEG, OP_COMP: begin
            we    = 1'b1;
            waddr = sp_r[SA_W-1:0];
            if (op_r == OP_NOT) begin
              wdata = word_t'(rd == '0);
            end else if (op_r == OP_NEG) begin
              wdata = -rd;
            end else begin
              wdata = ~rd;
            end
          end
          OP_JNEQ: begin
            if (rd == '0) begin
              npc_nxt = target;
            end
            nsp_nxt = sp_r - 1'b1;
          end
          OP_EVAL: begin
            if (!in_rng(rd_x)) begin
              flt_nxt = FLT_RANGE;
            end else begin
              rd_idx    = rd_x;
              state_nxt = S_RB;
            end
          end
          OP_ASSGN: begin
            if (!in_rng(rd_x)) begin
              flt_nxt = FLT_RANGE;
            end else begin
              ea_nxt    = rd[SA_W-1:0];
              rd_idx    = sp_x - 1;
              state_nxt = S_RB;
            end
          end
          OP_RET, OP_RETI: begin
            rd_idx    = bp_x + 2;
            state_nxt = S_RB;
          end
          default: begin
            // top word is the right operand
            b_nxt     = rd;
            rd_idx    = sp_x - 1;
            state_nxt = S_RB;
          end
        endcase
      end

      S_RB: begin
        state_nxt = S_TOP;
        unique case (op_r)
          OP_EVAL: begin
            we    = 1'b1;
            waddr = sp_r[SA_W-1:0];
            wdata = rd;
          end
          OP_ASSGN: begin
            we      = 1'b1;
            waddr   = ea_r;
            wdata   = rd;
            nsp_nxt = sp_r - SP_W'(2);
          end
          OP_RET, OP_RETI: begin
            npc_nxt = rd[PC_W-1:0];
            if (reti) begin
              rd_idx    = bp_x + 3;
              state_nxt = S_RC;
            end else begin
              state_nxt = S_RET;
            end
          end
          default: begin
            alu_req.start = 1'b1;
            state_nxt     = S_ALU;
          end
        endcase
      end

      S_RC: begin
        b_nxt     = rd;
        state_nxt = S_RET;
      end

      S_RET: begin
        state_nxt = S_TOP;
        tmp = bp_x - 1 - opd_x + (reti ? EXT_W'(1) : EXT_W'(0));
        if (!in_rng(a_x) || tmp < -1 || tmp >= EXT_W'(STACK_DEPTH) ||
            (reti && tmp < 0)) begin
          flt_nxt = FLT_RANGE;
        end else begin
          nbp_nxt = a_r[SA_W-1:0];
          nsp_nxt = tmp[SP_W-1:0];
          if (reti) begin
            we    = 1'b1;
            waddr = tmp[SA_W-1:0];
            wdata = b_r;
          end
        end
      end

      S_ALU: begin
        if (alu_rsp.done) begin
          state_nxt = S_TOP;
          if (alu_rsp.div0) begin
            flt_nxt = FLT_DIV0;
          end else begin
            we      = 1'b1;
            waddr   = SA_W'(sp_r - 1'b1);
            wdata   = alu_rsp.result;
            nsp_nxt = sp_r - 1'b1;
          end
        end
      end

      S_WALK: begin
        if (lvl_r == '0) begin
          state_nxt = S_TOP;
          if (op_r == OP_PUSHV) begin
            tmp = sp_x + 1;
            if (!in_rng(tmp)) begin
              flt_nxt = FLT_RANGE;
            end else begin
              we      = 1'b1;
              waddr   = tmp[SA_W-1:0];
              wdata   = b_r + opd_r;
              nsp_nxt = tmp[SP_W-1:0];
            end
          end else begin
            if (!in_rng(sp_x + 4) || sp_x + 1 < 0) begin
              flt_nxt = FLT_RANGE;
            end else begin
              step_nxt  = '0;
              state_nxt = S_CALL;
            end
          end
        end else if (!in_rng(b_x)) begin
          flt_nxt   = FLT_RANGE;
          state_nxt = S_TOP;
        end else begin
          rd_idx    = b_x;
          state_nxt = S_WALKD;
        end
      end

      S_WALKD: begin
        b_nxt     = rd;
        lvl_nxt   = lvl_r - 1'b1;
        state_nxt = S_WALK;
      end

      S_CALL: begin
        // frame: static link, old base, return address, return value
        we       = 1'b1;
        tmp      = sp_x + 1 + EXT_W'(step_r);
        waddr    = tmp[SA_W-1:0];
        step_nxt = step_r + 1'b1;
        unique case (step_r)
          2'd0: wdata = b_r;
          2'd1: wdata = word_t'(bp_r);
          2'd2: wdata = word_t'(pc1);
          default: wdata = '0;
        endcase
        if (step_r == 2'd3) begin
          nbp_nxt   = SA_W'(sp_r + 1'b1);
          nsp_nxt   = sp_r + SP_W'(4);
          npc_nxt   = target;
          state_nxt = S_TOP;
        end
      end

      S_TOP: begin
        // commit and fetch the new top word once the output slot is free
        if (!ov_r || out_ch.ready) begin
          if (flt_r != FLT_NONE) begin
            npc_nxt = pc_r;
            nsp_nxt = sp_r;
            nbp_nxt = bp_r;
          end
          pc_nxt    = (flt_r != FLT_NONE) ? pc_r : npc_r;
          sp_nxt    = (flt_r != FLT_NONE) ? sp_r : nsp_r;
          bp_nxt    = (flt_r != FLT_NONE) ? bp_r : nbp_r;
          rd_idx    = (flt_r != FLT_NONE) ? sp_x : EXT_W'(nsp_r);
          state_nxt = S_TOPW;
        end
      end

      S_TOPW: begin
        ov_nxt     = 1'b1;
        o_pc_nxt   = pc_r;
        o_top_nxt  = rd;
        o_idx_nxt  = sp_r;
        o_halt_nxt = (pc_r == '0);
        o_flt_nxt  = flt_r;
        state_nxt  = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase

    if (we && waddr < SA_W'(4)) begin
      lowv_nxt[waddr[1:0]] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pc_r    <= '0;
      sp_r    <= SP_W'(3);
      bp_r    <= '0;
      lowv_r  <= '0;
      ov_r    <= 1'b0;
      flt_r   <= FLT_NONE;
      lvl_r   <= '0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      sp_r    <= sp_nxt;
      bp_r    <= bp_nxt;
      lowv_r  <= lowv_nxt;
      ov_r    <= ov_nxt;
      flt_r   <= flt_nxt;
      lvl_r   <= lvl_nxt;
      step_r  <= step_nxt;
    end
    op_r     <= op_nxt;
    opd_r    <= opd_nxt;
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    ea_r     <= ea_nxt;
    npc_r    <= npc_nxt;
    nsp_r    <= nsp_nxt;
    nbp_r    <= nbp_nxt;
    rz_r     <= rz_nxt;
    o_pc_r   <= o_pc_nxt;
    o_top_r  <= o_top_nxt;
    o_idx_r  <= o_idx_nxt;
    o_halt_r <= o_halt_nxt;
    o_flt_r  <= o_flt_nxt;
  end

  assign out_ch.valid     = ov_r;
  assign out_ch.next_pc   = o_pc_r;
  assign out_ch.top_value = o_top_r;
  assign out_ch.top_index = o_idx_r;
  assign out_ch.halted    = o_halt_r;
  assign out_ch.fault     = o_flt_r;
endmodule

>>> design/smie_ram.sv
module smie_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> design/smie_alu.sv
module smie_alu import smie_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  alu_req_t req,
  output alu_rsp_t rsp
);
  logic              busy_r, busy_nxt;
  logic              fin_r, fin_nxt;
  logic              done_r, done_nxt;
  logic              dz_r, dz_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  word_t             rem_r, rem_nxt;
  word_t             quo_r, quo_nxt;
  word_t             dvs_r, dvs_nxt;
  word_t             res_r, res_nxt;
  logic              negq_r, negq_nxt;
  logic              negr_r, negr_nxt;
  logic              isrem_r, isrem_nxt;
  word_t             fast;
  logic [WORD_BITS:0] sh, diff;
  logic              big;

  assign big = (req.b >> SHW) != '0;

  always_comb begin
    unique case (req.op)
      OP_ADD:  fast = req.a + req.b;
      OP_SUB:  fast = req.a - req.b;
      OP_MUL:  fast = WORD_BITS'(req.a * req.b);
      OP_BOR:  fast = req.a | req.b;
      OP_BAND: fast = req.a & req.b;
      OP_BXOR: fast = req.a ^ req.b;
      OP_LSH:  fast = big ? '0 : req.a << req.b[SHW-1:0];
      OP_RSH:  fast = big ? word_t'($signed(req.a) >>> (WORD_BITS - 1))
                          : word_t'($signed(req.a) >>> req.b[SHW-1:0]);
      OP_EQU:  fast = word_t'(req.a == req.b);
      OP_NEQ:  fast = word_t'(req.a != req.b);
      OP_LT:   fast = word_t'($signed(req.a) <  $signed(req.b));
      OP_GTE:  fast = word_t'($signed(req.a) >= $signed(req.b));
      OP_GT:   fast = word_t'($signed(req.a) >  $signed(req.b));
      OP_LTE:  fast = word_t'($signed(req.a) <= $signed(req.b));
      OP_LOR:  fast = word_t'(req.a != '0 || req.b != '0);
      OP_LAND: fast = word_t'(req.a != '0 && req.b != '0);
      default: fast = '0;
    endcase
  end

  // one restoring step per cycle on magnitudes
  assign sh   = {rem_r, quo_r[WORD_BITS-1]};
  assign diff = sh - {1'b0, dvs_r};

  always_comb begin
    busy_nxt  = busy_r;
    fin_nxt   = 1'b0;
    done_nxt  = 1'b0;
    dz_nxt    = dz_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    dvs_nxt   = dvs_r;
    res_nxt   = res_r;
    negq_nxt  = negq_r;
    negr_nxt  = negr_r;
    isrem_nxt = isrem_r;
    if (req.start) begin
      dz_nxt = 1'b0;
      if (req.op == OP_DIV || req.op == OP_REM) begin
        if (req.b == '0) begin
          dz_nxt   = 1'b1;
          done_nxt = 1'b1;
        end else begin
          busy_nxt  = 1'b1;
          cnt_nxt   = '0;
          rem_nxt   = '0;
          quo_nxt   = req.a[WORD_BITS-1] ? -req.a : req.a;
          dvs_nxt   = req.b[WORD_BITS-1] ? -req.b : req.b;
          negq_nxt  = req.a[WORD_BITS-1] ^ req.b[WORD_BITS-1];
          negr_nxt  = req.a[WORD_BITS-1];
          isrem_nxt = (req.op == OP_REM);
        end
      end else begin
        res_nxt  = fast;
        done_nxt = 1'b1;
      end
    end else if (busy_r) begin
      if (!diff[WORD_BITS]) begin
        rem_nxt = diff[WORD_BITS-1:0];
      end else begin
        rem_nxt = sh[WORD_BITS-1:0];
      end
      quo_nxt = {quo_r[WORD_BITS-2:0], ~diff[WORD_BITS]};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(WORD_BITS - 1)) begin
        busy_nxt = 1'b0;
        fin_nxt  = 1'b1;
      end
    end else if (fin_r) begin
      if (isrem_r) begin
        res_nxt = negr_r ? -rem_r : rem_r;
      end else begin
        res_nxt = negq_r ? -quo_r : quo_r;
      end
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      dz_r   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      fin_r  <= fin_nxt;
      done_r <= done_nxt;
      dz_r   <= dz_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    dvs_r   <= dvs_nxt;
    res_r   <= res_nxt;
    negq_r  <= negq_nxt;
    negr_r  <= negr_nxt;
    isrem_r <= isrem_nxt;
  end

  assign rsp.done   = done_r;
  assign rsp.div0   = dz_r;
  assign rsp.result = res_r;
endmodule

>>> test/stack_machine_instruction_executor_tb.sv
`timescale 1ns / 1ps

module stack_machine_instruction_executor_tb;
  import smie_pkg::*;

  localparam int  RAND_ITEMS  = 1900;
  localparam int  CYCLE_LIMIT = 10000000;
  localparam int  LONG_HOLD   = 400;

  // one decoded instruction
  typedef struct packed {
    opcode_t    op;
    logic [7:0] lvl;
    word_t      opd;
  } instr_t;

  // one result as the block reports it
  typedef struct packed {
    logic [PC_W-1:0] pc;
    word_t           top;
    logic [SP_W-1:0] idx;
    logic            halted;
    fault_t          flt;
  } step_res_t;

  // directed stimulus row, expected result typed in where chk is set
  typedef struct packed {
    instr_t    ins;
    logic      chk;
    step_res_t exp;
  } dir_row_t;

  logic clk;
  logic rst_n;

  smie_in_if  in_ch();
  smie_out_if out_ch();

  stack_machine_instruction_executor u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // machine state mirrored by the predictor
  logic [PC_W-1:0] pc_q;
  longint          sp_q;
  longint          bp_q;
  word_t           stack_mem [STACK_DEPTH];
  bit              stack_wr  [STACK_DEPTH];
  bit              stale_read;

  step_res_t pending_results [$];
  instr_t    plan [$];
  dir_row_t  dir_rows [$];

  int  in_idle_pct;
  int  out_idle_pct;
  bit  hold_req;
  int  cycles;
  int  mismatches;
  int  results_seen;
  int  faults_seen;
  int  halts_seen;
  int  items_sent;

  // clock, 8 ns period
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // runaway guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected",
               cycles, pending_results.size());
      $display("stack_machine_instruction_executor_tb: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic bit in_stack(input longint i);
    return i >= 0 && i < STACK_DEPTH;
  endfunction

  // reads a stack word, noting any read of a word never written
  function automatic word_t peek(input longint i);
    if (!stack_wr[i]) stale_read = 1'b1;
    return stack_mem[i];
  endfunction

  // static link walk from the frame base
  function automatic bit follow_links(input logic [7:0] n, output word_t base);
    longint idx;
    base = word_t'(bp_q);
    for (int i = 0; i < n; i++) begin
      idx = $signed(base);
      if (!in_stack(idx)) return 1'b0;
      base = peek(idx);
    end
    return 1'b1;
  endfunction

  // two-operand ops: a is next-to-top, b is top
  function automatic fault_t alu_op(input opcode_t op, input word_t a, input word_t b,
                                    output word_t r);
    r = '0;
    case (op)
      OP_ADD:  r = a + b;
      OP_SUB:  r = a - b;
      OP_MUL:  r = a * b;
      OP_DIV, OP_REM: begin
        if (b == '0) return FLT_DIV0;
        // most negative / -1 wraps, remainder 0
        if (b == '1) r = (op == OP_DIV) ? -a : '0;
        else         r = (op == OP_DIV) ? $signed(a) / $signed(b) : $signed(a) % $signed(b);
      end
      OP_BOR:  r = a | b;
      OP_BAND: r = a & b;
      OP_BXOR: r = a ^ b;
      // amounts of a word or more flush out or fill with sign
      OP_LSH:  r = (b >= WORD_BITS) ? '0 : a << b[SHW-1:0];
      OP_RSH:  r = (b >= WORD_BITS) ? {WORD_BITS{a[WORD_BITS-1]}}
                                    : word_t'($signed(a) >>> b[SHW-1:0]);
      OP_EQU:  r = word_t'(a == b);
      OP_NEQ:  r = word_t'(a != b);
      OP_LT:   r = word_t'($signed(a) <  $signed(b));
      OP_GTE:  r = word_t'($signed(a) >= $signed(b));
      OP_GT:   r = word_t'($signed(a) >  $signed(b));
      OP_LTE:  r = word_t'($signed(a) <= $signed(b));
      OP_LOR:  r = word_t'(a != '0 || b != '0);
      default: r = word_t'(a != '0 && b != '0);
    endcase
    return FLT_NONE;
  endfunction

  // executes one instruction on the mirrored machine; state changes only when
  // commit is set; returns 0 if any word never written would be read
  function automatic bit exec_instr(input instr_t ins, input bit commit, output step_res_t res);
    longint          so, nsp, nbp, t, nb, ea;
    logic [PC_W-1:0] pc1, npc, tgt;
    fault_t          flt;
    word_t           a, b, r, lnk, keep;
    int              np;
    longint          wi [4];
    word_t           wv [4];
    bit              hit;
    stale_read = 1'b0;
    so  = $signed(ins.opd);
    pc1 = pc_q + 1'b1;
    tgt = ins.opd[PC_W-1:0];
    npc = pc1;
    nsp = sp_q;
    nbp = bp_q;
    flt = FLT_NONE;
    np  = 0;
    case (ins.op)
      OP_NOT, OP_NEG, OP_COMP: begin
        if (!in_stack(sp_q)) flt = FLT_RANGE;
        else begin
          a = peek(sp_q);
          r = (ins.op == OP_NOT) ? word_t'(a == '0) : (ins.op == OP_NEG) ? -a : ~a;
          wi[0] = sp_q; wv[0] = r; np = 1;
        end
      end
      OP_PUSHC: begin
        if (!in_stack(sp_q + 1)) flt = FLT_RANGE;
        else begin
          wi[0] = sp_q + 1; wv[0] = ins.opd; np = 1; nsp = sp_q + 1;
        end
      end
      OP_PUSHV: begin
        if (!follow_links(ins.lvl, lnk) || !in_stack(sp_q + 1)) flt = FLT_RANGE;
        else begin
          wi[0] = sp_q + 1; wv[0] = lnk + ins.opd; np = 1; nsp = sp_q + 1;
        end
      end
      OP_EVAL: begin
        if (!in_stack(sp_q)) flt = FLT_RANGE;
        else begin
          ea = $signed(peek(sp_q));
          if (!in_stack(ea)) flt = FLT_RANGE;
          else begin
            wi[0] = sp_q; wv[0] = peek(ea); np = 1;
          end
        end
      end
      OP_ASSGN: begin
        if (!in_stack(sp_q) || sp_q < 1) flt = FLT_RANGE;
        else begin
          ea = $signed(peek(sp_q));
          if (!in_stack(ea)) flt = FLT_RANGE;
          else begin
            wi[0] = ea; wv[0] = peek(sp_q - 1); np = 1; nsp = sp_q - 2;
          end
        end
      end
      OP_CALL: begin
        // frame: static link, old base, return address, return value
        if (!follow_links(ins.lvl, lnk) || !in_stack(sp_q + 4) || sp_q + 1 < 0)
          flt = FLT_RANGE;
        else begin
          wi[0] = sp_q + 1; wv[0] = lnk;
          wi[1] = sp_q + 2; wv[1] = word_t'(bp_q);
          wi[2] = sp_q + 3; wv[2] = word_t'(pc1);
          wi[3] = sp_q + 4; wv[3] = '0;
          np  = 4;
          nbp = sp_q + 1;
          nsp = sp_q + 4;
          npc = tgt;
        end
      end
      OP_RET, OP_RETI: begin
        if (!in_stack(bp_q + 3)) flt = FLT_RANGE;
        else begin
          nb   = $signed(peek(bp_q + 1));
          t    = bp_q - 1 - so;
          keep = '0;
          if (ins.op == OP_RETI) begin
            keep = peek(bp_q + 3);
            t    = t + 1;
          end
          if (!in_stack(nb) || t < -1 || t >= STACK_DEPTH ||
              (ins.op == OP_RETI && !in_stack(t))) flt = FLT_RANGE;
          else begin
            a   = peek(bp_q + 2);
            npc = a[PC_W-1:0];
            if (ins.op == OP_RETI) begin
              wi[0] = t; wv[0] = keep; np = 1;
            end
            nbp = nb;
            nsp = t;
          end
        end
      end
      OP_ENTER: begin
        t = sp_q + so;
        if (t < -1 || t >= STACK_DEPTH) flt = FLT_RANGE;
        else nsp = t;
      end
      OP_JUMP: npc = tgt;
      OP_JNEQ: begin
        if (!in_stack(sp_q)) flt = FLT_RANGE;
        else begin
          if (peek(sp_q) == '0) npc = tgt;
          nsp = sp_q - 1;
        end
      end
      OP_BAD: flt = FLT_OPC;
      default: begin
        if (!in_stack(sp_q) || sp_q < 1) flt = FLT_RANGE;
        else begin
          a   = peek(sp_q - 1);
          b   = peek(sp_q);
          flt = alu_op(ins.op, a, b, r);
          if (flt == FLT_NONE) begin
            wi[0] = sp_q - 1; wv[0] = r; np = 1; nsp = sp_q - 1;
          end
        end
      end
    endcase

    // a faulted step leaves everything as it was
    if (flt != FLT_NONE) begin
      npc = pc_q;
      nsp = sp_q;
      nbp = bp_q;
      np  = 0;
    end

    // top of stack after this step's writes; empty stack reads as 0
    res.top = '0;
    if (in_stack(nsp)) begin
      hit = 1'b0;
      for (int k = 0; k < np; k++)
        if (wi[k] == nsp) begin
          res.top = wv[k];
          hit     = 1'b1;
        end
      if (!hit) res.top = peek(nsp);
    end
    res.pc     = npc;
    res.idx    = nsp[SP_W-1:0];
    res.halted = (npc == '0);
    res.flt    = flt;

    if (commit) begin
      for (int k = 0; k < np; k++) begin
        stack_mem[wi[k]] = wv[k];
        stack_wr[wi[k]]  = 1'b1;
      end
      pc_q = npc;
      sp_q = nsp;
      bp_q = nbp;
    end
    return !stale_read;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic instr_t mk(input opcode_t op, input int lvl, input word_t opd);
    instr_t i;
    i.op  = op;
    i.lvl = lvl[7:0];
    i.opd = opd;
    return i;
  endfunction

  function automatic dir_row_t plain_row(input opcode_t op, input int lvl, input word_t opd);
    dir_row_t d;
    d.ins = mk(op, lvl, opd);
    d.chk = 1'b0;
    d.exp = '0;
    return d;
  endfunction

  function automatic dir_row_t checked_row(input opcode_t op, input int lvl, input word_t opd,
                                           input int epc, input word_t etop, input int eidx,
                                           input bit ehalt, input fault_t eflt);
    dir_row_t d;
    d.ins        = mk(op, lvl, opd);
    d.chk        = 1'b1;
    d.exp.pc     = epc[PC_W-1:0];
    d.exp.top    = etop;
    d.exp.idx    = eidx[SP_W-1:0];
    d.exp.halted = ehalt;
    d.exp.flt    = eflt;
    return d;
  endfunction

  // mostly shallow static nesting, now and then the full range
  function automatic int pick_level();
    int k;
    k = $urandom_range(0, 99);
    if (k < 80) return $urandom_range(0, 2);
    if (k < 95) return $urandom_range(0, 7);
    return $urandom_range(0, 255);
  endfunction

  function automatic word_t rand_word();
    case ($urandom_range(0, 4))
      0, 1: return $urandom;
      2:    return word_t'($urandom_range(0, 48)) - 8;
      3: begin
        case ($urandom_range(0, 5))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return '0;
          3: return 32'd1;
          4: return '1;
          default: return 32'd32;
        endcase
      end
      default: return word_t'($urandom_range(0, (sp_q > 0) ? sp_q + 1 : 4));
    endcase
  endfunction

  function automatic instr_t any_instr();
    int k;
    k = $urandom_range(0, 99);
    if (k < 22) return mk(OP_PUSHC, pick_level(), rand_word());
    if (k < 50) return mk(opcode_t'(OP_ADD + $urandom_range(0, 17)), pick_level(), $urandom);
    if (k < 56) return mk(opcode_t'(OP_NOT + $urandom_range(0, 2)), pick_level(), $urandom);
    if (k < 62) return mk(OP_PUSHV, pick_level(), $urandom_range(0, 4));
    if (k < 66) return mk(OP_EVAL, pick_level(), $urandom);
    if (k < 70) return mk(OP_ASSGN, pick_level(), $urandom);
    if (k < 75) return mk(OP_CALL, pick_level(), $urandom);
    if (k < 81)
      return mk($urandom_range(0, 1) ? OP_RET : OP_RETI, pick_level(),
                ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 2));
    if (k < 88) begin
      if ($urandom_range(0, 9) == 0) return mk(OP_ENTER, pick_level(), $urandom);
      // keep the stack from creeping toward the top
      if (sp_q > 500) return mk(OP_ENTER, 0, -word_t'($urandom_range(1, 64)));
      return mk(OP_ENTER, pick_level(), word_t'($urandom_range(0, 6)) - 4);
    end
    if (k < 92) return mk(OP_JUMP, pick_level(), $urandom);
    if (k < 98) return mk(OP_JNEQ, pick_level(), $urandom);
    return mk(OP_BAD, pick_level(), $urandom);
  endfunction

  // well-formed fragments: load, store, procedure, branch, arithmetic
  task automatic plan_fragment();
    int n;
    case ($urandom_range(0, 4))
      0: begin
        plan.push_back(mk(OP_PUSHV, $urandom_range(0, 2), $urandom_range(0, 4)));
        plan.push_back(mk(OP_EVAL, 0, 0));
      end
      1: begin
        plan.push_back(mk(OP_PUSHC, 0, rand_word()));
        plan.push_back(mk(OP_PUSHV, $urandom_range(0, 2), $urandom_range(0, 4)));
        plan.push_back(mk(OP_ASSGN, 0, 0));
      end
      2: begin
        plan.push_back(mk(OP_CALL, pick_level(), $urandom));
        n = $urandom_range(0, 3);
        repeat (n) plan.push_back(mk(OP_PUSHC, 0, rand_word()));
        if (n >= 2) plan.push_back(mk(opcode_t'(OP_ADD + $urandom_range(0, 17)), 0, 0));
        plan.push_back(mk($urandom_range(0, 1) ? OP_RETI : OP_RET, 0, 0));
      end
      3: begin
        plan.push_back(mk(OP_PUSHC, 0, rand_word()));
        plan.push_back(mk(OP_PUSHC, 0, rand_word()));
        plan.push_back(mk(opcode_t'(OP_EQU + $urandom_range(0, 7)), 0, 0));
        plan.push_back(mk(OP_JNEQ, 0, $urandom));
      end
      default: begin
        plan.push_back(mk(OP_PUSHC, 0, rand_word()));
        plan.push_back(mk(OP_PUSHC, 0, rand_word()));
        plan.push_back(mk(opcode_t'(OP_ADD + $urandom_range(0, 9)), 0, 0));
      end
    endcase
  endtask

  // offers one item at the falling edge and holds it until taken; on
  // acceptance the predictor steps and the expectation is queued
  task automatic send_item(input instr_t ins, input bit chk, input step_res_t typed);
    step_res_t pred;
    bit        ok;
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= ins.op;
    in_ch.level     <= ins.lvl;
    in_ch.operand   <= ins.opd;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    ok = exec_instr(ins, 1'b1, pred);
    pending_results.push_back(chk ? typed : pred);
    items_sent++;
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  // receiver back-pressure, with an occasional long hold while the sender keeps going
  initial begin
    int hold_left;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = LONG_HOLD;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= out_idle_pct);
      end
    end
  end

  // compare each result with the oldest expectation
  always @(posedge clk) begin
    step_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (out_ch.fault != FLT_NONE) faults_seen++;
      if (out_ch.halted) halts_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result at cycle %0d: pc %0h top %0h", cycles,
                   out_ch.next_pc, out_ch.top_value);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.next_pc !== want.pc || out_ch.top_value !== want.top ||
            out_ch.top_index !== want.idx || out_ch.halted !== want.halted ||
            out_ch.fault !== want.flt) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"result %0d mismatch: exp pc %0h top %0h idx %0h halt %0b flt %0d,",
                      " got pc %0h top %0h idx %0h halt %0b flt %0d"},
                     results_seen, want.pc, want.top, want.idx, want.halted, want.flt,
                     out_ch.next_pc, out_ch.top_value, out_ch.top_index, out_ch.halted,
                     out_ch.fault);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    instr_t    ins;
    step_res_t scratch;
    int        tries;

    cycles          = 0;
    mismatches      = 0;
    results_seen    = 0;
    faults_seen     = 0;
    halts_seen      = 0;
    items_sent      = 0;
    hold_req        = 1'b0;
    in_idle_pct     = 32;
    out_idle_pct    = 77;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.operation = '0;
    in_ch.level     = '0;
    in_ch.operand   = '0;

    // reset state: pc 0, sp 3, base 0, words 0 to 3 zero
    pc_q = '0;
    sp_q = 3;
    bp_q = 0;
    for (int i = 0; i < STACK_DEPTH; i++) begin
      stack_mem[i] = '0;
      stack_wr[i]  = (i < 4);
    end

    // directed program; typed rows are the obvious extremes and fault codes
    dir_rows.push_back(checked_row(OP_PUSHC, 0, 32'h7fff_ffff, 1, 32'h7fff_ffff, 4, 0, FLT_NONE));
    dir_rows.push_back(checked_row(OP_PUSHC, 0, 32'h8000_0000, 2, 32'h8000_0000, 5, 0, FLT_NONE));
    dir_rows.push_back(plain_row(OP_PUSHC, 0, '1));
    // most negative over -1 wraps to itself
    dir_rows.push_back(checked_row(OP_DIV, 0, 0, 4, 32'h8000_0000, 5, 0, FLT_NONE));
    dir_rows.push_back(plain_row(OP_PUSHC, 0, 0));
    // remainder by zero faults, nothing moves
    dir_rows.push_back(checked_row(OP_REM, 0, 0, 5, 0, 6, 0, FLT_DIV0));
    dir_rows.push_back(plain_row(OP_NOT, 0, 0));
    dir_rows.push_back(plain_row(OP_NEG, 0, 0));
    dir_rows.push_back(plain_row(OP_COMP, 0, 0));
    dir_rows.push_back(plain_row(OP_BOR, 0, 0));
    dir_rows.push_back(plain_row(OP_PUSHC, 0, 40));
    // oversized right shift fills with sign
    dir_rows.push_back(checked_row(OP_RSH, 0, 0, 11, 32'hffff_ffff, 5, 0, FLT_NONE));
    dir_rows.push_back(plain_row(OP_PUSHC, 0, 33));
    // oversized left shift clears
    dir_rows.push_back(checked_row(OP_LSH, 0, 0, 13, 0, 5, 0, FLT_NONE));
    dir_rows.push_back(plain_row(OP_ADD, 0, 0));
    dir_rows.push_back(plain_row(OP_SUB, 0, 0));
    dir_rows.push_back(plain_row(OP_MUL, 0, 0));
    dir_rows.push_back(plain_row(OP_BAND, 0, 0));
    dir_rows.push_back(plain_row(OP_BXOR, 0, 0));
    // binary op with a single word on the stack
    dir_rows.push_back(checked_row(OP_EQU, 0, 0, 18, 0, 0, 0, FLT_RANGE));
    dir_rows.push_back(plain_row(OP_PUSHC, 0, 5));
    dir_rows.push_back(plain_row(OP_ENTER, 0, 5));
    dir_rows.push_back(plain_row(OP_NEQ, 0, 0));
    dir_rows.push_back(plain_row(OP_LT, 0, 0));
    dir_rows.push_back(plain_row(OP_GTE, 0, 0));
    dir_rows.push_back(plain_row(OP_GT, 0, 0));
    dir_rows.push_back(plain_row(OP_LTE, 0, 0));
    dir_rows.push_back(plain_row(OP_LOR, 0, 0));
    dir_rows.push_back(plain_row(OP_PUSHC, 0, 2));
    dir_rows.push_back(plain_row(OP_LAND, 0, 0));
    dir_rows.push_back(plain_row(OP_PUSHV, 0, 1));
    dir_rows.push_back(plain_row(OP_EVAL, 0, 0));
    dir_rows.push_back(plain_row(OP_PUSHC, 0, 9));
    dir_rows.push_back(plain_row(OP_PUSHC, 0, 3));
    dir_rows.push_back(plain_row(OP_ASSGN, 0, 0));
    dir_rows.push_back(checked_row(OP_CALL, 0, 100, 100, 0, 5, 0, FLT_NONE));
    dir_rows.push_back(plain_row(OP_ENTER, 0, 1));
    dir_rows.push_back(plain_row(OP_PUSHC, 0, 77));
    dir_rows.push_back(plain_row(OP_RETI, 0, 0));
    // zero on top branches to address 0, which halts
    dir_rows.push_back(checked_row(OP_JNEQ, 0, 0, 0, 1, 1, 1, FLT_NONE));
    // jump target reduced modulo code depth
    dir_rows.push_back(checked_row(OP_JUMP, 0, 32'hffff_f123, 32'h123, 1, 1, 0, FLT_NONE));
    dir_rows.push_back(checked_row(OP_BAD, 0, 0, 32'h123, 1, 1, 0, FLT_OPC));
    dir_rows.push_back(checked_row(OP_ENTER, 0, 2000, 32'h123, 1, 1, 0, FLT_RANGE));
    // main returns: empty stack, top reads 0
    dir_rows.push_back(checked_row(OP_RET, 0, 0, 0, 0, -1, 1, FLT_NONE));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i])
      send_item(dir_rows[i].ins, dir_rows[i].chk, dir_rows[i].exp);

    // random part in three idle phases; long receiver hold opens the second
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == RAND_ITEMS / 3) begin
        in_idle_pct  = 77;
        out_idle_pct = 32;
        hold_req     = 1'b1;
      end else if (n == 2 * RAND_ITEMS / 3) begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end
      if (plan.size() == 0) begin
        if ($urandom_range(0, 99) < 45) plan_fragment();
        else plan.push_back(any_instr());
      end
      ins = plan.pop_front();
      // never touch a stack word that was not written; emptying the stack always works
      tries = 0;
      while (!exec_instr(ins, 1'b0, scratch)) begin
        plan.delete();
        tries++;
        ins = (tries < 30) ? any_instr() : mk(OP_ENTER, 0, word_t'(-(sp_q + 1)));
      end
      send_item(ins, 1'b0, scratch);
    end
    in_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("%0d instructions issued, %0d results checked (%0d faulted, %0d halted)",
             items_sent, results_seen, faults_seen, halts_seen);
    $display("three back-pressure phases plus one long output stall, %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("stack_machine_instruction_executor_tb: PASS");
    end else begin
      $display("stack_machine_instruction_executor_tb: FAIL");
    end
    $finish;
  end

endmodule
